[design/byte_vertical_delta_decoder_core_defines.svh]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder assertion macros
// Concurrent check wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_VERTICAL_DELTA_DECODER_CORE_DEFINES_SVH
`define BYTE_VERTICAL_DELTA_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bvd assertion failed");
`define BVD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bvd reset assertion failed");
`else
`define BVD_ASSERT(lbl, prop)
`define BVD_ASSERT_RST(lbl, prop)
`endif

`endif

[design/bvd_pkg.sv]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder package
// Shared types, register indexes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bvd_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_XOR_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd200;
  localparam logic [16:0] ROW_MAX          = 17'h1FFFF;
  localparam logic [8:0]  LEN_FULL         = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_OPCODE    = 3'd1,
    ST_RUN_COUNT = 3'd2,
    ST_RUN_VALUE = 3'd3,
    ST_LITERAL   = 3'd4
  } bvd_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       column_start;
    logic [2:0] plane_index;
    logic [7:0] column_index;
  } bvd_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  out_plane;
    logic [7:0]  out_column;
    logic [15:0] start_row;
    logic [8:0]  span_length;
    logic [7:0]  span_value;
    logic        combine_xor;
    logic        row_overflow;
  } bvd_result_t;

  typedef struct packed {
    logic        xor_mode;
    logic [15:0] frame_height;
  } bvd_cfg_t;

  // remainder by a small elaboration-time divisor, restoring compare/subtract
  function automatic logic [7:0] bvd_rem(input logic [7:0] val, input logic [8:0] dvs);
    logic [15:0] r;
    logic [15:0] sub;
    r = {8'd0, val};
    for (int k = 7; k >= 0; k--) begin
      sub = {7'd0, dvs} << k;
      if (r >= sub) begin
        r = r - sub;
      end
    end
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

[design/bvd_if.sv]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder channels
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       column_start;
  logic [2:0] plane_index;
  logic [7:0] column_index;

  modport source (output valid, data_byte, column_start, plane_index, column_index,
                  input ready);
  modport sink   (input valid, data_byte, column_start, plane_index, column_index,
                  output ready);
endinterface

interface bvd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  out_plane;
  logic [7:0]  out_column;
  logic [15:0] start_row;
  logic [8:0]  span_length;
  logic [7:0]  span_value;
  logic        combine_xor;
  logic        row_overflow;

  modport source (output valid, kind, out_plane, out_column, start_row, span_length,
                  span_value, combine_xor, row_overflow, input ready);
  modport sink   (input valid, kind, out_plane, out_column, start_row, span_length,
                  span_value, combine_xor, row_overflow, output ready);
endinterface

interface bvd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

[design/bvd_in_stage.sv]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder input register
// Captures one input transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bvd_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  bvd_in_if.sink               in_i,
  input  wire logic            advance_i,
  output bvd_pkg::bvd_item_t   item_o,
  output logic                 item_valid_o
);
  import bvd_pkg::*;

  logic      valid_q, valid_d;
  bvd_item_t item_q;
  logic      take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data_byte    <= in_i.data_byte;
      item_q.column_start <= in_i.column_start;
      item_q.plane_index  <= in_i.plane_index;
      item_q.column_index <= in_i.column_index;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

[design/bvd_parser.sv]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder op parser
// Tracks the column's op stream and forms span results and stray results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_vertical_delta_decoder_core_defines.svh"

module bvd_parser #(
  parameter int unsigned MAX_PLANES  = 8,
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire bvd_pkg::bvd_item_t item_i,
  input  wire bvd_pkg::bvd_cfg_t  cfg_i,
  output bvd_pkg::bvd_result_t   res_o,
  output logic                   res_valid_o
);
  import bvd_pkg::*;

  bvd_state_e  state_q, state_d;
  logic [7:0]  ops_left_q, ops_left_d;
  logic [8:0]  bytes_left_q, bytes_left_d;
  logic [8:0]  run_count_q, run_count_d;
  logic [16:0] row_pos_q, row_pos_d;
  logic [2:0]  held_plane_q, held_plane_d;
  logic [7:0]  held_column_q, held_column_d;

  logic [7:0]  d;
  logic [7:0]  ops_dec;
  logic [8:0]  bytes_dec;
  logic [8:0]  adv_n;
  logic [17:0] row_sum;
  logic [16:0] row_adv;
  logic [8:0]  span_len;
  logic [17:0] span_end;

  assign d         = item_i.data_byte;
  assign ops_dec   = ops_left_q - 8'd1;
  assign bytes_dec = bytes_left_q - 9'd1;

  always_comb begin
    case (state_q)
      ST_OPCODE:    adv_n = {1'b0, d};
      ST_RUN_VALUE: adv_n = run_count_q;
      default:      adv_n = 9'd1;
    endcase
  end

  assign row_sum = {1'b0, row_pos_q} + {9'd0, adv_n};
  assign row_adv = row_sum[17] ? ROW_MAX : row_sum[16:0];

  // next state
  always_comb begin
    state_d       = state_q;
    ops_left_d    = ops_left_q;
    bytes_left_d  = bytes_left_q;
    run_count_d   = run_count_q;
    row_pos_d     = row_pos_q;
    held_plane_d  = held_plane_q;
    held_column_d = held_column_q;
    if (fire_i) begin
      if (item_i.column_start) begin
        held_plane_d  = 3'(bvd_rem({5'd0, item_i.plane_index}, 9'(MAX_PLANES)));
        held_column_d = bvd_rem(item_i.column_index, 9'(MAX_COLUMNS));
        ops_left_d    = d;
        row_pos_d     = '0;
        bytes_left_d  = '0;
        run_count_d   = '0;
        state_d       = (d != 8'd0) ? ST_OPCODE : ST_IDLE;
      end else begin
        case (state_q)
          ST_OPCODE: begin
            if (d == 8'd0) begin
              state_d = ST_RUN_COUNT;
            end else if (d[7]) begin
              bytes_left_d = (d[6:0] != 7'd0) ? {2'b00, d[6:0]} : LEN_FULL;
              state_d      = ST_LITERAL;
            end else begin
              row_pos_d  = row_adv;
              ops_left_d = ops_dec;
              state_d    = (ops_dec == 8'd0) ? ST_IDLE : ST_OPCODE;
            end
          end
          ST_RUN_COUNT: begin
            run_count_d = (d != 8'd0) ? {1'b0, d} : LEN_FULL;
            state_d     = ST_RUN_VALUE;
          end
          ST_RUN_VALUE: begin
            row_pos_d  = row_adv;
            ops_left_d = ops_dec;
            state_d    = (ops_dec == 8'd0) ? ST_IDLE : ST_OPCODE;
          end
          ST_LITERAL: begin
            row_pos_d    = row_adv;
            bytes_left_d = bytes_dec;
            if (bytes_dec == 9'd0) begin
              ops_left_d = ops_dec;
              state_d    = (ops_dec == 8'd0) ? ST_IDLE : ST_OPCODE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  assign span_len = (state_q == ST_RUN_VALUE) ? run_count_q : 9'd1;
  assign span_end = {1'b0, row_pos_q} + {9'd0, span_len};

  // result
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = 1'b0;
    res_o.out_plane    = held_plane_q;
    res_o.out_column   = held_column_q;
    res_o.start_row    = row_pos_q[16] ? 16'hFFFF : row_pos_q[15:0];
    res_o.span_length  = span_len;
    res_o.span_value   = d;
    res_o.combine_xor  = cfg_i.xor_mode;
    res_o.row_overflow = span_end > {2'b00, cfg_i.frame_height};
    case (state_q)
      ST_OPCODE, ST_RUN_COUNT: begin
        res_valid_o = 1'b0;
      end
      ST_RUN_VALUE, ST_LITERAL: begin
        res_valid_o = fire_i && !item_i.column_start;
      end
      default: begin
        res_valid_o        = fire_i && !item_i.column_start;
        res_o.kind         = 1'b1;
        res_o.span_length  = 9'd0;
        res_o.combine_xor  = 1'b0;
        res_o.row_overflow = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ops_left_q    <= '0;
      bytes_left_q  <= '0;
      run_count_q   <= '0;
      row_pos_q     <= '0;
      held_plane_q  <= '0;
      held_column_q <= '0;
    end else begin
      state_q       <= state_d;
      ops_left_q    <= ops_left_d;
      bytes_left_q  <= bytes_left_d;
      run_count_q   <= run_count_d;
      row_pos_q     <= row_pos_d;
      held_plane_q  <= held_plane_d;
      held_column_q <= held_column_d;
    end
  end

  `BVD_ASSERT(a_literal_has_bytes, (state_q == ST_LITERAL) |-> (bytes_left_q != 9'd0))
  `BVD_ASSERT(a_busy_has_ops, (state_q != ST_IDLE) |-> (ops_left_q != 8'd0))
  `BVD_ASSERT(a_col_start_row0, (fire_i && item_i.column_start) |=> (row_pos_q == 17'd0))
  `BVD_ASSERT(a_result_on_fire, res_valid_o |-> fire_i)
  `BVD_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE))

endmodule

`default_nettype wire

[design/bvd_out_stage.sv]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder result register
// Holds one result until the receiver completes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bvd_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bvd_pkg::bvd_result_t res_i,
  input  wire logic            res_valid_i,
  output logic                 slot_free_o,
  bvd_out_if.source            out_o
);
  import bvd_pkg::*;

  logic        valid_q, valid_d;
  bvd_result_t res_q;

  assign slot_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.out_plane    = res_q.out_plane;
  assign out_o.out_column   = res_q.out_column;
  assign out_o.start_row    = res_q.start_row;
  assign out_o.span_length  = res_q.span_length;
  assign out_o.span_value   = res_q.span_value;
  assign out_o.combine_xor  = res_q.combine_xor;
  assign out_o.row_overflow = res_q.row_overflow;

endmodule

`default_nettype wire

[design/byte_vertical_delta_decoder_core.sv]
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder core
// Decodes a byte column's delta op stream into write spans.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one delta byte per transfer, with column_start on the op-count
//            byte and the plane/column tags taken from that byte.
//   out_o  : one span (kind 0) per run value or literal byte, or one stray
//            record (kind 1) for a byte that arrives outside any column.
//            Op-count, opcode, skip and run-count bytes give no result.
//   cfg_i  : register writes, index 0 xor_mode, index 1 frame_height; always
//            ready; user writes only while the core is idle (not enforced).
// Each result passes the input register, then the result register.
// Throughput: one byte per cycle unless the receiver stalls; the parse
// state updates in a single pass.
// Reset clears the parser to idle, empties both registers and loads
// xor_mode 0, frame_height 200.
// A stalled receiver holds the result register; one more byte waits in the
// input register, then in_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_vertical_delta_decoder_core #(
  parameter int unsigned MAX_PLANES  = 8,
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bvd_in_if.sink     in_i,
  bvd_out_if.source  out_o,
  bvd_cfg_if.sink    cfg_i
);
  import bvd_pkg::*;

  bvd_cfg_t    cfg_q;
  bvd_item_t   item;
  logic        item_valid;
  logic        slot_free;
  logic        fire;
  bvd_result_t res;
  logic        res_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xor_mode     <= 1'b0;
      cfg_q.frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_XOR_MODE:     cfg_q.xor_mode     <= cfg_i.wdata[0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_i.wdata;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  assign fire = item_valid && slot_free;

  bvd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .advance_i    (fire),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  bvd_parser #(
    .MAX_PLANES  (MAX_PLANES),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  bvd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_valid_i (res_valid),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte-vertical delta decoder testbench
// Drives byte columns (skips, runs, literals, stray and abandoned bytes)
// through the core with random gaps and output stalls. A local decoder model
// predicts each span, and every result transfer is checked field by field in
// order. Registers are rewritten between rounds while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import bvd_pkg::*;

  localparam int unsigned PLANES       = 8;
  localparam int unsigned COLUMNS      = 256;
  localparam int unsigned ROUND_ITEMS  = 35;
  localparam int unsigned DRAIN_CYCLES = 6;

  localparam logic [7:0] OP_RUN     = 8'h00;
  localparam logic [7:0] OP_LITERAL = 8'h80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bvd_in_if  in_if ();
  bvd_out_if out_if ();
  bvd_cfg_if cfg_if ();

  byte_vertical_delta_decoder_core #(
    .MAX_PLANES  (PLANES),
    .MAX_COLUMNS (COLUMNS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  // decoder model state
  bvd_state_e  prs_state;
  logic [7:0]  ops_left;
  logic [8:0]  bytes_left;
  logic [8:0]  run_len;
  logic [16:0] row_pos;
  logic [2:0]  cur_plane;
  logic [7:0]  cur_col;
  logic        cfg_xor;
  logic [15:0] cfg_height;
  bvd_result_t span_queue[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cnt  = 0;
  bit          steady     = 1'b0;

  function automatic void push_span(logic kind, logic [8:0] len, logic [7:0] val);
    bvd_result_t s;
    s.kind         = kind;
    s.out_plane    = cur_plane;
    s.out_column   = cur_col;
    s.start_row    = row_pos[16] ? 16'hFFFF : row_pos[15:0];
    s.span_length  = len;
    s.span_value   = val;
    s.combine_xor  = kind ? 1'b0 : cfg_xor;
    s.row_overflow = kind ? 1'b0 : (({1'b0, row_pos} + 18'(len)) > 18'(cfg_height));
    span_queue.push_back(s);
  endfunction

  function automatic void advance_rows(logic [8:0] n);
    logic [17:0] r;
    r = {1'b0, row_pos} + 18'(n);
    row_pos = (r > 18'(ROW_MAX)) ? ROW_MAX : r[16:0];
  endfunction

  function automatic void close_op();
    ops_left  = ops_left - 8'd1;
    prs_state = (ops_left == 8'd0) ? ST_IDLE : ST_OPCODE;
  endfunction

  function automatic void decode_byte(bvd_item_t it);
    logic [7:0] d;
    d = it.data_byte;
    if (it.column_start) begin
      cur_plane  = 3'(int'(it.plane_index) % PLANES);
      cur_col    = 8'(int'(it.column_index) % COLUMNS);
      ops_left   = d;
      row_pos    = '0;
      bytes_left = '0;
      run_len    = '0;
      prs_state  = (d != 8'd0) ? ST_OPCODE : ST_IDLE;
      return;
    end
    case (prs_state)
      ST_OPCODE: begin
        if (d == OP_RUN) begin
          prs_state = ST_RUN_COUNT;
        end else if (d[7]) begin
          bytes_left = (d[6:0] != 7'd0) ? {2'b00, d[6:0]} : LEN_FULL;
          prs_state  = ST_LITERAL;
        end else begin
          advance_rows({1'b0, d});
          close_op();
        end
      end
      ST_RUN_COUNT: begin
        run_len   = (d != 8'd0) ? {1'b0, d} : LEN_FULL;
        prs_state = ST_RUN_VALUE;
      end
      ST_RUN_VALUE: begin
        push_span(1'b0, run_len, d);
        advance_rows(run_len);
        close_op();
      end
      ST_LITERAL: begin
        push_span(1'b0, 9'd1, d);
        advance_rows(9'd1);
        bytes_left = bytes_left - 9'd1;
        if (bytes_left == 9'd0) begin
          close_op();
        end
      end
      default: begin
        prs_state = ST_IDLE;
        push_span(1'b1, 9'd0, d);
      end
    endcase
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_span();
    bvd_result_t want;
    if (span_queue.size() == 0) begin
      $error("result transfer with nothing expected: kind %0d value %0d",
             out_if.kind, out_if.span_value);
      mismatches++;
      return;
    end
    want = span_queue.pop_front();
    cmp_field("kind", want.kind, out_if.kind);
    cmp_field("out_plane", want.out_plane, out_if.out_plane);
    cmp_field("out_column", want.out_column, out_if.out_column);
    cmp_field("start_row", want.start_row, out_if.start_row);
    cmp_field("span_length", want.span_length, out_if.span_length);
    cmp_field("span_value", want.span_value, out_if.span_value);
    cmp_field("combine_xor", want.combine_xor, out_if.combine_xor);
    cmp_field("row_overflow", want.row_overflow, out_if.row_overflow);
  endfunction

  // mostly short gaps, a few long ones; none while steady
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_span();
    end
    if (stall_cnt != 0) begin
      stall_cnt--;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_cnt = pick_gap();
    end
    out_if.ready <= (stall_cnt == 0);
  end

  task automatic send_item(bvd_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= it.data_byte;
    in_if.column_start <= it.column_start;
    in_if.plane_index  <= it.plane_index;
    in_if.column_index <= it.column_index;
    do @(posedge clk_i); while (!in_if.ready);
    decode_byte(it);
    items_sent++;
  endtask

  task automatic send_start(logic [7:0] n_ops, logic [2:0] plane, logic [7:0] col);
    bvd_item_t it;
    it = '{data_byte: n_ops, column_start: 1'b1, plane_index: plane, column_index: col};
    send_item(it);
  endtask

  // tags are ignored off column start, so they carry random bits
  task automatic send_data(logic [7:0] d);
    bvd_item_t it;
    it = '{data_byte: d, column_start: 1'b0, plane_index: 3'($urandom),
           column_index: 8'($urandom)};
    send_item(it);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (span_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(logic xm, logic [15:0] height);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= REG_XOR_MODE;
    cfg_if.wdata     <= {15'd0, xm};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_xor = xm;
    cfg_if.reg_index <= REG_FRAME_HEIGHT;
    cfg_if.wdata     <= height;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_height = height;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_op();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      send_data(8'($urandom_range(1, 127)));
    end else if (sel < 60) begin
      send_data(OP_RUN);
      send_data(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom));
      send_data(8'($urandom));
    end else begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 127) : $urandom_range(1, 4);
      send_data(OP_LITERAL | 8'(n));
      repeat (n) send_data(8'($urandom));
    end
  endtask

  task automatic send_column(bit broken);
    int unsigned n_ops;
    n_ops = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    send_start(8'(n_ops), 3'($urandom), 8'($urandom));
    for (int unsigned i = 0; i < n_ops; i++) begin
      if (broken && $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          send_data(OP_RUN);
          send_data(8'($urandom));
        end else begin
          send_data(OP_LITERAL | 8'($urandom_range(3, 20)));
          send_data(8'($urandom));
        end
        return;
      end
      send_op();
    end
  endtask

  task automatic send_noise();
    bvd_item_t it;
    repeat ($urandom_range(1, 3)) begin
      it = '{data_byte: 8'($urandom), column_start: ($urandom_range(0, 3) == 0),
             plane_index: 3'($urandom), column_index: 8'($urandom)};
      send_item(it);
    end
  endtask

  // reset state: stray bytes carry the held tags
  task automatic test_stray_bytes();
    send_data(8'hA5);
    send_start(8'd0, 3'd7, 8'd255);
    send_data(8'h00);
  endtask

  // default registers; literal straddles the frame_height boundary
  task automatic test_default_regs();
    send_start(8'd4, 3'd5, 8'h3C);
    send_data(8'h7F);
    send_data(8'd72);
    send_data(OP_LITERAL | 8'd2);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(OP_RUN);
    send_data(8'd0);
    send_data(8'h5A);
    send_data(8'h7F);
  endtask

  task automatic test_column_restart();
    send_start(8'd3, 3'd2, 8'd9);
    send_data(OP_RUN);
    send_data(8'd5);
    send_start(8'd1, 3'd1, 8'h80);
    send_data(OP_LITERAL | 8'd3);
    send_data(8'h11);
    send_start(8'd2, 3'd3, 8'd1);
    send_data(8'd10);
    send_data(OP_RUN);
    send_data(8'd255);
    send_data(8'h33);
    send_start(8'd0, 3'd6, 8'd0);
    send_data(8'hC3);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    apply_config(1'b1, 16'd1);
    send_start(8'd2, 3'd4, 8'd200);
    send_data(OP_RUN);
    send_data(8'd1);
    send_data(8'h80);
    send_data(OP_LITERAL | 8'd1);
    send_data(8'h01);
    wait_idle();
    apply_config(1'b1, 16'd0);
    send_start(8'd1, 3'd0, 8'd17);
    send_data(OP_LITERAL | 8'd1);
    send_data(8'hEE);
    wait_idle();
    apply_config(1'b0, 16'hFFFF);
    send_start(8'd1, 3'd3, 8'd128);
    send_data(OP_RUN);
    send_data(8'd0);
    send_data(8'h42);
  endtask

  // full-length literal then full-length run
  task automatic test_long_spans();
    wait_idle();
    apply_config(1'($urandom), 16'($urandom_range(100, 400)));
    steady = 1'b0;
    send_start(8'd2, 3'($urandom), 8'($urandom));
    send_data(OP_LITERAL);
    repeat (256) send_data(8'($urandom));
    send_data(OP_RUN);
    send_data(8'd0);
    send_data(8'($urandom));
  endtask

  task automatic test_random_rounds();
    int unsigned goal;
    int unsigned sel;
    logic [15:0] height;
    for (int rnd = 0; rnd < 4; rnd++) begin
      wait_idle();
      case (rnd)
        0:       height = 16'($urandom_range(1, 64));
        1:       height = 16'hFFFF;
        2:       height = 16'($urandom_range(100, 1500));
        default: height = 16'($urandom);
      endcase
      apply_config(1'($urandom), height);
      steady = (rnd == 2);
      goal = items_sent + ROUND_ITEMS;
      while (items_sent < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          send_column(1'b0);
        end else if (sel < 90) begin
          send_column(1'b1);
        end else begin
          send_noise();
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.column_start = 1'b0;
    in_if.plane_index  = '0;
    in_if.column_index = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.reg_index   = REG_XOR_MODE;
    cfg_if.wdata       = '0;
    prs_state  = ST_IDLE;
    ops_left   = '0;
    bytes_left = '0;
    run_len    = '0;
    row_pos    = '0;
    cur_plane  = '0;
    cur_col    = '0;
    cfg_xor    = 1'b0;
    cfg_height = FRAME_HEIGHT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stray_bytes();
    test_default_regs();
    test_column_restart();
    test_config_extremes();
    test_long_spans();
    test_random_rounds();
    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[byte_vertical_delta_decoder_core.f]
+incdir+design
design/bvd_pkg.sv
design/bvd_if.sv
design/bvd_in_stage.sv
design/bvd_parser.sv
design/bvd_out_stage.sv
design/byte_vertical_delta_decoder_core.sv
tb/tb_top.sv
